[sv/htm_pkg.sv]
`timescale 1ns / 1ps
// htm_pkg: shared widths, fixed-point constants, operator codes and helpers
// for the tone mapper. No dependencies.
package htm_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 8;
  localparam int CH_W       = INT_BITS + FRAC_BITS;  // input channel width
  localparam int VAL_W      = 40;                    // intermediate width
  localparam int HALF_W     = VAL_W / 2;
  localparam int CODE_W     = 8;
  localparam int NUM_CH     = 3;
  localparam int DIV_STAGES = VAL_W;                 // one quotient bit per stage
  localparam int DIV_LAT    = DIV_STAGES + 1;        // plus the entry stage

  localparam logic [VAL_W-1:0] SAT_CAP = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] ONE_Q   = VAL_W'(1) << FRAC_BITS;

  // Curve constants, Q16 after truncation from Q24
  localparam logic [VAL_W-1:0] K_CA    = 40'd9830;    // 0.15
  localparam logic [VAL_W-1:0] K_CB    = 40'd32768;   // 0.50
  localparam logic [VAL_W-1:0] K_CCCB  = 40'd3276;    // C*B
  localparam logic [VAL_W-1:0] K_CDCE  = 40'd261;     // D*E
  localparam logic [VAL_W-1:0] K_CDCF  = 40'd3931;    // D*F
  localparam logic [VAL_W-1:0] K_CECF  = 40'd4366;    // E/F
  localparam logic [VAL_W-1:0] K_SCALE = 40'd90374;   // 1 / partial(11.2)
  localparam logic [VAL_W-1:0] K_PRE   = 40'd39321;   // 0.6
  localparam logic [VAL_W-1:0] K_AA    = 40'd164495;  // 2.51
  localparam logic [VAL_W-1:0] K_AB    = 40'd1966;    // 0.03
  localparam logic [VAL_W-1:0] K_AC    = 40'd159252;  // 2.43
  localparam logic [VAL_W-1:0] K_AD    = 40'd38666;   // 0.59
  localparam logic [VAL_W-1:0] K_AE    = 40'd9175;    // 0.14

  // Rec.709 luminance weights, Q24; index 0 red
  localparam logic [NUM_CH-1:0][23:0] LUM_WT = {24'd1211315, 24'd11999065, 24'd3566836};

  localparam logic [CH_W-1:0] WHITE_RST = 24'd327680;  // 5.0

  typedef enum logic [2:0] {
    OP_CLAMP        = 3'd0,
    OP_REINHARD     = 3'd1,
    OP_REINHARD_EXT = 3'd2,
    OP_EXT_LUM      = 3'd3,
    OP_FILMIC       = 3'd4,
    OP_ACES         = 3'd5
  } op_e;

  localparam logic [0:0] REG_OPERATOR  = 1'b0;
  localparam logic [0:0] REG_MAX_WHITE = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] hh;
    logic [VAL_W-1:0] hl;
    logic [VAL_W-1:0] lh;
    logic [VAL_W-1:0] ll;
  } mul_pp_t;

  typedef struct packed {
    op_e                          mode;
    logic [CH_W-1:0]              lum;
    logic [NUM_CH-1:0][CH_W-1:0]  c;
    logic [NUM_CH-1:0][CH_W-1:0]  x;
  } side_a_t;

  typedef struct packed {
    op_e                          mode;
    logic [CH_W-1:0]              lum;
    logic [NUM_CH-1:0][CH_W-1:0]  c;
  } side_b_t;

  typedef struct packed {
    op_e                          mode;
    logic [CH_W-1:0]              lum;
    logic [NUM_CH-1:0][CH_W-1:0]  c;
    logic [NUM_CH-1:0][VAL_W-1:0] p;
  } side_c_t;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? SAT_CAP : s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // First half of a saturating Q16 product: four 20x20 partial products
  function automatic mul_pp_t mul_part(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b);
    mul_pp_t r;
    r.hh = {{HALF_W{1'b0}}, a[VAL_W-1:HALF_W]} * {{HALF_W{1'b0}}, b[VAL_W-1:HALF_W]};
    r.hl = {{HALF_W{1'b0}}, a[VAL_W-1:HALF_W]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
    r.lh = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[VAL_W-1:HALF_W]};
    r.ll = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
    return r;
  endfunction

  // Second half: sum, drop fraction, saturate
  function automatic logic [VAL_W-1:0] mul_sum(input mul_pp_t p);
    logic [2*VAL_W-1:0] s;
    s = {p.hh, {VAL_W{1'b0}}}
      + {{HALF_W{1'b0}}, p.hl, {HALF_W{1'b0}}}
      + {{HALF_W{1'b0}}, p.lh, {HALF_W{1'b0}}}
      + {{VAL_W{1'b0}}, p.ll};
    return (|s[2*VAL_W-1:VAL_W+FRAC_BITS]) ? SAT_CAP : s[VAL_W+FRAC_BITS-1:FRAC_BITS];
  endfunction

endpackage

[sv/hdr_tone_mapper.sv]
`timescale 1ns / 1ps
// hdr_tone_mapper: throughput one pixel per cycle while the output is not stalled;
// set by three fully pipelined 41-stage dividers in series (white point, curve
// quotient, luminance ratio).
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears valid bits; operator resets to ACES, white point to 5.0.
module hdr_tone_mapper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [htm_pkg::CH_W-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [htm_pkg::CH_W-1:0]   red_in_i,
  input  logic [htm_pkg::CH_W-1:0]   green_in_i,
  input  logic [htm_pkg::CH_W-1:0]   blue_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [htm_pkg::CODE_W-1:0] red_out_o,
  output logic [htm_pkg::CODE_W-1:0] green_out_o,
  output logic [htm_pkg::CODE_W-1:0] blue_out_o
);
  import htm_pkg::*;

  // input, luma x2, divA, three mul pairs, num/den, divB, sub, divC, mul pair, code
  localparam int LAT = 3 + 3 * DIV_LAT + 6 + 1 + 1 + 2 + 1;
  localparam int LP_W = CH_W + 24;

  // ---------------- configuration ----------------
  op_e             op_q;
  logic [CH_W-1:0] white_q;
  logic [2*CH_W-1:0] wsq;
  logic [31:0]     w2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_ACES;
      white_q <= WHITE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OPERATOR:  op_q    <= op_e'(cfg_data_i[2:0]);
        REG_MAX_WHITE: white_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // W^2 is a settled function of the white point; never saturates
  assign wsq = {{CH_W{1'b0}}, white_q} * {{CH_W{1'b0}}, white_q};
  always_ff @(posedge clk_i) begin
    w2_q <= wsq[FRAC_BITS+31:FRAC_BITS];
  end

  // ---------------- flow control ----------------
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // ---------------- input and luminance ----------------
  op_e                         s0_mode_q, s1_mode_q, s2_mode_q;
  logic [NUM_CH-1:0][CH_W-1:0] s0_c_q, s1_c_q, s2_c_q, s2_x_q;
  logic [NUM_CH-1:0][LP_W-1:0] s1_lp_q;
  logic [CH_W-1:0]             s2_lum_q;
  logic [LP_W-1:0]             lum_sum;

  assign lum_sum = s1_lp_q[0] + s1_lp_q[1] + s1_lp_q[2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_c_q    <= {blue_in_i, green_in_i, red_in_i};
      s0_mode_q <= op_q;
      s1_mode_q <= s0_mode_q;
      s1_c_q    <= s0_c_q;
      for (int i = 0; i < NUM_CH; i++) begin
        s1_lp_q[i] <= {24'b0, s0_c_q[i]} * {{CH_W{1'b0}}, LUM_WT[i]};
      end
      s2_mode_q <= s1_mode_q;
      s2_c_q    <= s1_c_q;
      s2_lum_q  <= lum_sum[LP_W-1:24];
      // luminance mode runs the extended Reinhard curve on luma in every lane
      for (int i = 0; i < NUM_CH; i++) begin
        s2_x_q[i] <= (s1_mode_q == OP_EXT_LUM) ? lum_sum[LP_W-1:24] : s1_c_q[i];
      end
    end
  end

  // ---------------- divider A: x / W^2 ----------------
  logic [NUM_CH-1:0][VAL_W-1:0] da;
  side_a_t sa_q [0:DIV_LAT-1];

  for (genvar g = 0; g < NUM_CH; g++) begin : g_div_a
    htm_div u_div_a (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (VAL_W'(s2_x_q[g])),
      .b_i   (VAL_W'(w2_q)),
      .q_o   (da[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q[0] <= '{mode: s2_mode_q, lum: s2_lum_q, c: s2_c_q, x: s2_x_q};
      for (int k = 1; k < DIV_LAT; k++) sa_q[k] <= sa_q[k-1];
    end
  end

  // ---------------- multiply chain ----------------
  side_a_t m1a_side_q, m1b_side_q, m2a_side_q, m2b_side_q, m3a_side_q, m3b_side_q;
  mul_pp_t [NUM_CH-1:0] m1_pp_d, m1_pp_q;
  mul_pp_t [NUM_CH-1:0] m2_p1_q, m2_p2_q;
  mul_pp_t [NUM_CH-1:0] m3_pn_d, m3_pd_d, m3_pn_q, m3_pd_q;
  logic [NUM_CH-1:0][VAL_W-1:0] m1_u_q, m2a_u_q, m2b_u_q, m3a_u_q, m3b_u_q;
  logic [NUM_CH-1:0][VAL_W-1:0] m2_t1_q, m2_t2_q, m3_n_q, m3_dn_q;
  logic [NUM_CH-1:0][VAL_W-1:0] nd_num_d, nd_den_d, nd_num_q, nd_den_q;
  logic [NUM_CH-1:0][VAL_W-1:0] y_a, y_b;
  side_b_t nd_side_q;

  // first product: x*(x/W^2 + 1), 0.15*y, or 0.6*x
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      y_a[i] = VAL_W'(sa_q[DIV_LAT-1].x[i]) << 1;
      case (sa_q[DIV_LAT-1].mode)
        OP_REINHARD_EXT, OP_EXT_LUM:
          m1_pp_d[i] = mul_part(VAL_W'(sa_q[DIV_LAT-1].x[i]), sat_add(da[i], ONE_Q));
        OP_FILMIC:
          m1_pp_d[i] = mul_part(K_CA, y_a[i]);
        OP_ACES:
          m1_pp_d[i] = mul_part(VAL_W'(sa_q[DIV_LAT-1].x[i]), K_PRE);
        default:
          m1_pp_d[i] = mul_part(VAL_W'(sa_q[DIV_LAT-1].x[i]), '0);
      endcase
    end
  end

  // numerator and denominator products of the two curves
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      y_b[i] = VAL_W'(m2b_side_q.x[i]) << 1;
      case (m2b_side_q.mode)
        OP_FILMIC: begin
          m3_pn_d[i] = mul_part(y_b[i], sat_add(m2b_u_q[i], K_CCCB));
          m3_pd_d[i] = mul_part(y_b[i], sat_add(m2b_u_q[i], K_CB));
        end
        default: begin
          m3_pn_d[i] = mul_part(m2b_u_q[i], sat_add(m2_t1_q[i], K_AB));
          m3_pd_d[i] = mul_part(m2b_u_q[i], sat_add(m2_t2_q[i], K_AD));
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      case (m3b_side_q.mode)
        OP_REINHARD_EXT, OP_EXT_LUM: begin
          nd_num_d[i] = m3b_u_q[i];
          nd_den_d[i] = sat_add(VAL_W'(m3b_side_q.x[i]), ONE_Q);
        end
        OP_FILMIC: begin
          nd_num_d[i] = sat_add(m3_n_q[i], K_CDCE);
          nd_den_d[i] = sat_add(m3_dn_q[i], K_CDCF);
        end
        OP_ACES: begin
          nd_num_d[i] = m3_n_q[i];
          nd_den_d[i] = sat_add(m3_dn_q[i], K_AE);
        end
        default: begin  // plain Reinhard; clamp ignores this path
          nd_num_d[i] = VAL_W'(m3b_side_q.x[i]);
          nd_den_d[i] = sat_add(VAL_W'(m3b_side_q.x[i]), ONE_Q);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1a_side_q <= sa_q[DIV_LAT-1];
      m1_pp_q    <= m1_pp_d;
      m1b_side_q <= m1a_side_q;
      for (int i = 0; i < NUM_CH; i++) m1_u_q[i] <= mul_sum(m1_pp_q[i]);
      m2a_side_q <= m1b_side_q;
      m2a_u_q    <= m1_u_q;
      for (int i = 0; i < NUM_CH; i++) begin
        m2_p1_q[i] <= mul_part(K_AA, m1_u_q[i]);
        m2_p2_q[i] <= mul_part(K_AC, m1_u_q[i]);
      end
      m2b_side_q <= m2a_side_q;
      m2b_u_q    <= m2a_u_q;
      for (int i = 0; i < NUM_CH; i++) begin
        m2_t1_q[i] <= mul_sum(m2_p1_q[i]);
        m2_t2_q[i] <= mul_sum(m2_p2_q[i]);
      end
      m3a_side_q <= m2b_side_q;
      m3a_u_q    <= m2b_u_q;
      m3_pn_q    <= m3_pn_d;
      m3_pd_q    <= m3_pd_d;
      m3b_side_q <= m3a_side_q;
      m3b_u_q    <= m3a_u_q;
      for (int i = 0; i < NUM_CH; i++) begin
        m3_n_q[i]  <= mul_sum(m3_pn_q[i]);
        m3_dn_q[i] <= mul_sum(m3_pd_q[i]);
      end
      nd_side_q <= '{mode: m3b_side_q.mode, lum: m3b_side_q.lum, c: m3b_side_q.c};
      nd_num_q  <= nd_num_d;
      nd_den_q  <= nd_den_d;
    end
  end

  // ---------------- divider B: curve quotient ----------------
  logic [NUM_CH-1:0][VAL_W-1:0] db;
  side_b_t sb_q [0:DIV_LAT-1];
  side_b_t p_side_q;
  logic [NUM_CH-1:0][VAL_W-1:0] p_q;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_div_b
    htm_div u_div_b (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (nd_num_q[g]),
      .b_i   (nd_den_q[g]),
      .q_o   (db[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= nd_side_q;
      for (int k = 1; k < DIV_LAT; k++) sb_q[k] <= sb_q[k-1];
      p_side_q <= sb_q[DIV_LAT-1];
      // filmic curve is floored at zero after the E/F offset
      for (int i = 0; i < NUM_CH; i++) begin
        p_q[i] <= (sb_q[DIV_LAT-1].mode == OP_FILMIC) ? sat_sub(db[i], K_CECF) : db[i];
      end
    end
  end

  // ---------------- divider C: luminance ratio ----------------
  logic [VAL_W-1:0] ratio;
  side_c_t sc_q [0:DIV_LAT-1];

  htm_div u_div_c (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (p_q[0]),
    .b_i   (VAL_W'(p_side_q.lum)),
    .q_o   (ratio)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_q[0] <= '{mode: p_side_q.mode, lum: p_side_q.lum, c: p_side_q.c, p: p_q};
      for (int k = 1; k < DIV_LAT; k++) sc_q[k] <= sc_q[k-1];
    end
  end

  // ---------------- final scale and code ----------------
  mul_pp_t [NUM_CH-1:0]         f1_pp_d, f1_pp_q;
  logic [NUM_CH-1:0][VAL_W-1:0] f1_pass_d, f1_pass_q, f2_m_q;
  logic [NUM_CH-1:0]            f1_use_d, f1_use_q;
  logic                         f1_black_q;
  logic [NUM_CH-1:0][23:0]      prod255;
  logic [NUM_CH-1:0][CODE_W-1:0] code_q;
  side_c_t                      sc_out;

  assign sc_out = sc_q[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      f1_pp_d[i]   = mul_part(VAL_W'(sc_out.c[i]), ratio);
      f1_pass_d[i] = VAL_W'(sc_out.c[i]);
      f1_use_d[i]  = 1'b0;
      case (sc_out.mode)
        OP_EXT_LUM: begin
          f1_use_d[i] = 1'b1;
        end
        OP_FILMIC: begin
          f1_pp_d[i]  = mul_part(sc_out.p[i], K_SCALE);
          f1_use_d[i] = 1'b1;
        end
        OP_REINHARD, OP_REINHARD_EXT, OP_ACES: begin
          f1_pass_d[i] = sc_out.p[i];
        end
        default: ;  // clamp passes the input through
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod255[i] = {8'b0, f2_m_q[i][FRAC_BITS-1:0]} * 24'd255;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_pp_q    <= f1_pp_d;
      f1_pass_q  <= f1_pass_d;
      f1_use_q   <= f1_use_d;
      // zero luma in luminance mode gives black
      f1_black_q <= (sc_out.mode == OP_EXT_LUM) && (sc_out.lum == '0);
      for (int i = 0; i < NUM_CH; i++) begin
        f2_m_q[i] <= f1_black_q  ? '0 :
                     f1_use_q[i] ? mul_sum(f1_pp_q[i]) : f1_pass_q[i];
      end
      for (int i = 0; i < NUM_CH; i++) begin
        code_q[i] <= (|f2_m_q[i][VAL_W-1:FRAC_BITS]) ? {CODE_W{1'b1}}
                                                     : prod255[i][FRAC_BITS+CODE_W-1:FRAC_BITS];
      end
    end
  end

  assign red_out_o   = code_q[0];
  assign green_out_o = code_q[1];
  assign blue_out_o  = code_q[2];

endmodule

[sv/htm_div.sv]
`timescale 1ns / 1ps
// htm_div: pipelined restoring divider, q = min(floor(a * 2^FRAC / b), cap).
// Depends on htm_pkg.
module htm_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [htm_pkg::VAL_W-1:0] a_i,
  input  logic [htm_pkg::VAL_W-1:0] b_i,
  output logic [htm_pkg::VAL_W-1:0] q_o
);
  import htm_pkg::*;

  logic [VAL_W-1:0] rem_q [0:DIV_STAGES-1];
  logic [VAL_W-1:0] nb_q  [0:DIV_STAGES-1];
  logic [VAL_W-1:0] quo_q [0:DIV_STAGES];
  logic [VAL_W-1:0] dv_q  [0:DIV_STAGES-1];
  logic [DIV_STAGES:0] sat_q;

  logic [VAL_W:0]        trial [0:DIV_STAGES-1];
  logic [VAL_W-1:0]      diff  [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0] ge;

  // remainder stays below the divisor, so the low bits of the difference suffice
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k] = {rem_q[k], nb_q[k][VAL_W-1]};
      diff[k]  = trial[k][VAL_W-1:0] - dv_q[k];
      ge[k]    = trial[k] >= {1'b0, dv_q[k]};
    end
  end

  // Quotient overflows the cap exactly when the top bits alone reach b
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= VAL_W'(a_i[VAL_W-1:VAL_W-FRAC_BITS]);
      nb_q[0]  <= {a_i[VAL_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      quo_q[0] <= '0;
      dv_q[0]  <= b_i;
      sat_q[0] <= VAL_W'(a_i[VAL_W-1:VAL_W-FRAC_BITS]) >= b_i;
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (k < DIV_STAGES - 1) begin
          rem_q[k+1] <= ge[k] ? diff[k] : trial[k][VAL_W-1:0];
          nb_q[k+1]  <= {nb_q[k][VAL_W-2:0], 1'b0};
          dv_q[k+1]  <= dv_q[k];
        end
        quo_q[k+1] <= {quo_q[k][VAL_W-2:0], ge[k]};
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign q_o = sat_q[DIV_STAGES] ? SAT_CAP : quo_q[DIV_STAGES];

endmodule

[tb/sv/tone_map_checker.sv]
`timescale 1ns / 1ps
// tone_map_checker: watches the config port and both channels of the tone mapper,
// predicts each output pixel and compares. Depends on htm_pkg.
module tone_map_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [htm_pkg::CH_W-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [htm_pkg::CH_W-1:0]   red_in_i,
  input  logic [htm_pkg::CH_W-1:0]   green_in_i,
  input  logic [htm_pkg::CH_W-1:0]   blue_in_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [htm_pkg::CODE_W-1:0] red_out_i,
  input  logic [htm_pkg::CODE_W-1:0] green_out_i,
  input  logic [htm_pkg::CODE_W-1:0] blue_out_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import htm_pkg::*;

  typedef logic [63:0] wide_t;
  typedef struct {
    logic [CODE_W-1:0] r;
    logic [CODE_W-1:0] g;
    logic [CODE_W-1:0] b;
  } rgb_code_t;

  localparam int    KSH = 24 - FRAC_BITS;
  localparam wide_t CAP = (64'd1 << 40) - 64'd1;
  localparam wide_t UNIT = 64'd1 << FRAC_BITS;
  localparam wide_t F_A = 64'd2516582 >> KSH, F_B = 64'd8388608 >> KSH;
  localparam wide_t F_C = 64'd1677722 >> KSH, F_D = 64'd3355443 >> KSH;
  localparam wide_t F_E = 64'd335544 >> KSH,  F_F = 64'd5033165 >> KSH;
  localparam wide_t F_WHITE = 64'd187904819 >> KSH;
  localparam wide_t A_PRE = 64'd10066330 >> KSH, A_A = 64'd42110812 >> KSH;
  localparam wide_t A_B = 64'd503316 >> KSH,     A_C = 64'd40768635 >> KSH;
  localparam wide_t A_D = 64'd9898557 >> KSH,    A_E = 64'd2348810 >> KSH;
  localparam wide_t W_R = 64'd3566836, W_G = 64'd11999065, W_B = 64'd1211315;

  logic [2:0]      op_q;
  logic [CH_W-1:0] white_q;
  rgb_code_t       pixel_q[$];

  function automatic wide_t clip_add(input wide_t a, input wide_t b);
    wide_t s;
    s = a + b;
    return (s > CAP) ? CAP : s;
  endfunction

  function automatic wide_t floor_sub(input wide_t a, input wide_t b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic wide_t qmul(input wide_t a, input wide_t b);
    wide_t ah, al;
    ah = a >> FRAC_BITS;
    al = a & (UNIT - 1);
    if (ah != 0 && b > CAP / ah) return CAP;
    return clip_add(ah * b, (al * b) >> FRAC_BITS);
  endfunction

  function automatic wide_t qdiv(input wide_t a, input wide_t b);
    wide_t q, r;
    if (b == 0) return CAP;
    q = a / b;
    r = a % b;
    if (q > (CAP >> FRAC_BITS)) return CAP;
    return clip_add(q << FRAC_BITS, (r << FRAC_BITS) / b);
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input wide_t v);
    wide_t t;
    if (v >= UNIT) return 8'd255;
    t = (v * 255) >> FRAC_BITS;
    return t[7:0];
  endfunction

  function automatic wide_t white_curve(input wide_t x, input wide_t w2);
    wide_t num;
    num = qmul(x, clip_add(qdiv(x, w2), UNIT));
    return qdiv(num, clip_add(x, UNIT));
  endfunction

  function automatic wide_t filmic(input wide_t y);
    wide_t ay, num, den;
    ay  = qmul(F_A, y);
    num = clip_add(qmul(y, clip_add(ay, qmul(F_C, F_B))), qmul(F_D, F_E));
    den = clip_add(qmul(y, clip_add(ay, F_B)), qmul(F_D, F_F));
    return floor_sub(qdiv(num, den), qdiv(F_E, F_F));
  endfunction

  function automatic wide_t aces(input wide_t x);
    wide_t v, num, den;
    v   = qmul(x, A_PRE);
    num = qmul(v, clip_add(qmul(A_A, v), A_B));
    den = clip_add(qmul(v, clip_add(qmul(A_C, v), A_D)), A_E);
    return qdiv(num, den);
  endfunction

  function automatic rgb_code_t map_pixel(input wide_t c0, input wide_t c1, input wide_t c2,
                                          input logic [2:0] op, input wide_t white);
    wide_t c[3], m[3];
    wide_t w2, lum, ratio, scale;
    rgb_code_t res;
    c[0] = c0; c[1] = c1; c[2] = c2;
    w2 = qmul(white, white);
    case (op)
      OP_REINHARD:     for (int i = 0; i < 3; i++) m[i] = qdiv(c[i], clip_add(c[i], UNIT));
      OP_REINHARD_EXT: for (int i = 0; i < 3; i++) m[i] = white_curve(c[i], w2);
      OP_EXT_LUM: begin
        lum = (c[0] * W_R + c[1] * W_G + c[2] * W_B) >> 24;
        if (lum == 0) begin
          // black pixel: luminance truncates to nothing
          for (int i = 0; i < 3; i++) m[i] = 0;
        end else begin
          ratio = qdiv(white_curve(lum, w2), lum);
          for (int i = 0; i < 3; i++) m[i] = qmul(c[i], ratio);
        end
      end
      OP_FILMIC: begin
        scale = qdiv(UNIT, filmic(F_WHITE));
        for (int i = 0; i < 3; i++) m[i] = qmul(filmic(c[i] << 1), scale);
      end
      OP_ACES:         for (int i = 0; i < 3; i++) m[i] = aces(c[i]);
      default:         for (int i = 0; i < 3; i++) m[i] = c[i];  // clamp, spare codes too
    endcase
    res.r = code_of(m[0]);
    res.g = code_of(m[1]);
    res.b = code_of(m[2]);
    return res;
  endfunction

  // codes may differ by one from the exact fixed-point result
  function automatic bit near(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b <= 1) : (b - a <= 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_code_t want;
    if (!rst_ni) begin
      op_q         <= OP_ACES;
      white_q      <= WHITE_RST;
      fail_count_o <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_OPERATOR) op_q <= cfg_data_i[2:0];
        else white_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i)
        pixel_q = {pixel_q, map_pixel(wide_t'(red_in_i), wide_t'(green_in_i),
                                      wide_t'(blue_in_i), op_q, wide_t'(white_q))};
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel %0d %0d %0d", $time,
                   red_out_i, green_out_i, blue_out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pixel_q.pop_front();
          if (!near(want.r, red_out_i) || !near(want.g, green_out_i) ||
              !near(want.b, blue_out_i)) begin
            if (fail_count_o < 30)
              $display("%0t: mismatch expected %0d %0d %0d actual %0d %0d %0d", $time,
                       want.r, want.g, want.b, red_out_i, green_out_i, blue_out_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = pixel_q.size();

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// tb: drives pixels and register writes into hdr_tone_mapper and gives the verdict.
// Depends on htm_pkg, hdr_tone_mapper and tone_map_checker.
module tb;
  import htm_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;  // unused selector codes act as clamp
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE = 150;                // longer than the whole pipeline

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [0:0]        cfg_index_i = REG_OPERATOR;
  logic [CH_W-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CH_W-1:0]   red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CODE_W-1:0] red_out_o, green_out_o, blue_out_o;
  int                fail_count, pending;

  int pixels_sent = 0;
  int burst_left  = 0;
  int settings    = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  logic [2:0]      op_list[8] = '{OP_CLAMP, OP_REINHARD, OP_REINHARD_EXT, OP_EXT_LUM,
                                  OP_FILMIC, OP_ACES, OP_SPARE_LO, OP_SPARE_HI};
  // white points: extremes of the range, default, 3.0, plus zero and one-lsb corners
  logic [CH_W-1:0] white_list[6] = '{24'd65536, 24'hFFFFFF, WHITE_RST, 24'd0, 24'd1,
                                     24'd196608};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  hdr_tone_mapper uut (.*);

  tone_map_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .red_in_i, .green_in_i, .blue_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .red_out_i(red_out_o),
    .green_out_i(green_out_o), .blue_out_i(blue_out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver back-pressure: the pattern is redrawn whenever its countdown runs out;
  // mode 0 is a clean stretch with no stalls at all.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      3:       out_stall_i <= (stall_left % 8 < 3);
      default: out_stall_i <= 1'b0;
    endcase
  end

  // One request; called and returns at a falling edge. Bursts end with a
  // random gap, valid only drops when the gap is nonzero.
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    int gap;
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    pixels_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Sender holds off until every result is back, then lets the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CH_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 4))
      0, 1:    return CH_W'($urandom);              // whole range, every bit
      2:       return CH_W'($urandom_range(0, 262143));  // below 4.0
      3:       return CH_W'($urandom_range(0, 65535));   // below 1.0
      default: return CH_W'($urandom_range(0, 255));     // near black
    endcase
  endfunction

  initial begin
    logic [2:0]      op;
    logic [CH_W-1:0] white;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: each selector code including the spare ones, with black, full scale, red at exactly one,
    // and, in luminance mode only, a pixel whose luminance truncates to zero.
    foreach (op_list[k]) begin
      write_reg(REG_OPERATOR, {21'd0, op_list[k]});
      send_pixel('0, '0, '0);
      send_pixel('1, '1, '1);
      send_pixel(24'd65536, 24'd1, 24'h800000);
      if (op_list[k] == OP_EXT_LUM) send_pixel('0, '0, 24'd1);
      drain();
      settings++;
    end

    // Random phases: mostly the two white-point operators over the listed and random
    // white points, with a few others, ending each phase with a full drain.
    for (int p = 0; p < 14; p++) begin
      op    = op_list[p % 8];
      white = (p < 6) ? white_list[p] : CH_W'($urandom_range(65536, 24'hFFFFFF));
      if (p % 3 == 0) op = OP_EXT_LUM;
      if (p % 3 == 1) op = OP_REINHARD_EXT;
      write_reg(REG_MAX_WHITE, white);
      write_reg(REG_OPERATOR, {21'd0, op});
      repeat (36) send_pixel(rand_channel(), rand_channel(), rand_channel());
      drain();
      settings++;
    end

    repeat (SETTLE) @(negedge clk_i);
    $display("Covered %0d pixels over %0d register settings, all eight selector codes,",
             pixels_sent, settings);
    $display("white points from zero to full scale, under random gaps and back-pressure.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timeout waiting for results");
    $display("Verification failed");
    $finish;
  end

endmodule

[hdr_tone_mapper.f]
sv/htm_pkg.sv
sv/htm_div.sv
sv/hdr_tone_mapper.sv
tb/sv/tone_map_checker.sv
tb/sv/tb.sv
